/* rtl/dsgs_pkg.sv */
// shared types, constants and the per-transaction and per-surface operation
// schedule for the drag surface grid search core; no dependencies
`default_nettype none

package dsgs_pkg;

  localparam int COEF_COUNT    = 24;
  localparam int COEF_AW       = 5;
  localparam int FRAC_BITS_DEF = 16;

  // operation schedule bounds
  localparam logic [5:0] OP_SURF_FIRST = 6'd6;
  localparam logic [5:0] OP_LAST       = 6'd47;

  // configuration register indexes
  localparam logic [1:0] REG_SURF_COUNT  = 2'd0;
  localparam logic [1:0] REG_SURFACE_MAX = 2'd1;
  localparam logic [1:0] REG_REF_AREA    = 2'd2;

  // command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef enum logic [4:0] {
    SRC_COEF, SRC_ONE, SRC_HALFC, SRC_RHO, SRC_MP1, SRC_MP2, SRC_MP3, SRC_MP4,
    SRC_MP5, SRC_MP6, SRC_S, SRC_S2, SRC_S3, SRC_S4, SRC_EXT, SRC_E2, SRC_ACC,
    SRC_T, SRC_D, SRC_HALF, SRC_AREA, SRC_VZ, SRC_V, SRC_ALT
  } src_t;

  typedef enum logic [3:0] {
    DST_MP2, DST_MP3, DST_MP4, DST_MP5, DST_MP6, DST_HALF, DST_S2, DST_S3,
    DST_S4, DST_ACC, DST_ADD, DST_EXT, DST_E2, DST_T, DST_D, DST_DRAG
  } dst_t;

  typedef struct packed {
    src_t               a_sel;
    src_t               b_sel;
    logic [COEF_AW-1:0] caddr;
    dst_t               dst;
  } uop_t;

  // mach power k as an operand
  function automatic src_t mp_src(input logic [2:0] k);
    src_t r;
    case (k)
      3'd1:    r = SRC_MP1;
      3'd2:    r = SRC_MP2;
      3'd3:    r = SRC_MP3;
      3'd4:    r = SRC_MP4;
      3'd5:    r = SRC_MP5;
      3'd6:    r = SRC_MP6;
      default: r = SRC_ONE;
    endcase
    return r;
  endfunction

  // saturating 32-bit add
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    return s[31:0];
  endfunction

  // schedule: ops 0..5 once per transaction, ops 6..47 once per surface
  function automatic uop_t uop_of(input logic [5:0] op);
    uop_t       u;
    logic [5:0] j;
    logic [2:0] k;
    u = '{SRC_COEF, SRC_ONE, 5'd0, DST_ADD};
    j = op - 6'd23;
    k = 3'(j[4:2]) + 3'd1;
    case (op) inside
      6'd0:  u = '{SRC_MP1, SRC_MP1, 5'd0, DST_MP2};
      6'd1:  u = '{SRC_MP2, SRC_MP1, 5'd0, DST_MP3};
      6'd2:  u = '{SRC_MP3, SRC_MP1, 5'd0, DST_MP4};
      6'd3:  u = '{SRC_MP4, SRC_MP1, 5'd0, DST_MP5};
      6'd4:  u = '{SRC_MP5, SRC_MP1, 5'd0, DST_MP6};
      6'd5:  u = '{SRC_HALFC, SRC_RHO, 5'd0, DST_HALF};
      6'd6:  u = '{SRC_S, SRC_S, 5'd0, DST_S2};
      6'd7:  u = '{SRC_S2, SRC_S, 5'd0, DST_S3};
      6'd8:  u = '{SRC_S3, SRC_S, 5'd0, DST_S4};
      6'd9:  u = '{SRC_COEF, SRC_S4, 5'd0, DST_ACC};
      6'd10: u = '{SRC_COEF, SRC_S3, 5'd1, DST_ADD};
      6'd11: u = '{SRC_COEF, SRC_S2, 5'd2, DST_ADD};
      6'd12: u = '{SRC_COEF, SRC_S, 5'd3, DST_EXT};
      6'd13: u = '{SRC_EXT, SRC_EXT, 5'd0, DST_E2};
      6'd14: u = '{SRC_COEF, SRC_ONE, 5'd4, DST_ACC};
      [6'd15:6'd20]: u = '{SRC_COEF, mp_src(3'(op - 6'd14)), 5'(op - 6'd10), DST_ADD};
      6'd21: u = '{SRC_COEF, SRC_EXT, 5'd11, DST_ADD};
      6'd22: u = '{SRC_COEF, SRC_E2, 5'd12, DST_ADD};
      [6'd23:6'd42]: begin
        case (j[1:0])
          2'd0:    u = '{SRC_COEF, SRC_EXT, 5'(11 + 2 * int'(k)), DST_T};
          2'd2:    u = '{SRC_COEF, SRC_E2, 5'(12 + 2 * int'(k)), DST_T};
          default: u = '{SRC_T, mp_src(k), 5'd0, DST_ADD};
        endcase
      end
      6'd43: u = '{SRC_COEF, SRC_ALT, 5'd23, DST_ADD};
      6'd44: u = '{SRC_HALF, SRC_AREA, 5'd0, DST_D};
      6'd45: u = '{SRC_D, SRC_ACC, 5'd0, DST_D};
      6'd46: u = '{SRC_D, SRC_VZ, 5'd0, DST_D};
      6'd47: u = '{SRC_D, SRC_V, 5'd0, DST_DRAG};
      default: u = '{SRC_COEF, SRC_ONE, 5'd0, DST_ADD};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

/* rtl/dsgs_fmul.sv */
// shared fixed-point multiplier: registered exact product, then floor
// shift and 32-bit saturation; no package dependency
`default_nettype none

module dsgs_fmul #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);

  logic signed [63:0] prod;
  logic signed [63:0] shifted;

  // exact product stage
  always_ff @(posedge clk) begin
    if (en) prod <= $signed(a) * $signed(b);
  end

  // arithmetic shift floors, then saturate
  always_comb begin
    shifted = prod >>> FRAC_BITS;
    if (shifted[63:31] == {33{1'b0}} || shifted[63:31] == {33{1'b1}}) y = shifted[31:0];
    else if (shifted[63]) y = 32'h8000_0000;
    else y = 32'h7fff_ffff;
  end

endmodule

`default_nettype wire

/* rtl/drag_surface_grid_search_core.sv */
// drag surface grid search core: coefficient memory, shared multiplier
// sequencer and surface stepping; uses dsgs_pkg and dsgs_fmul
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_stall   | cmd coef_index coef_value mach altitude
//           |                       | vert_speed speed density target_drag
//  out      | out_valid / out_stall | best_surface
//  cfg      | cfg_we                | cfg_index cfg_data
//
// a load transaction writes its coefficient without raising in_stall. after a
// compute transaction is accepted, in_stall stays high through the serial
// spacing divider, the six per-transaction operations, the surfaces (42
// operations each, all on the one shared multiplier) and the done state, which
// also waits while an earlier result is still stalled.
// a surf_count of zero goes from the accept straight to the done state.
// rst is synchronous; coefficient entries read as zero until loaded.
// a finished result waits in the output register while the next item is taken.
`default_nettype none

module drag_surface_grid_search_core #(
  parameter int FRAC_BITS = dsgs_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [4:0]  coef_index,
  input  wire logic [31:0] coef_value,
  input  wire logic [31:0] mach,
  input  wire logic [31:0] altitude,
  input  wire logic [31:0] vert_speed,
  input  wire logic [31:0] speed,
  input  wire logic [31:0] density,
  input  wire logic [31:0] target_drag,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      best_surface,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);

  import dsgs_pkg::*;

  localparam logic [31:0] ONE   = 32'(1) << FRAC_BITS;
  localparam logic [31:0] HALFC = 32'(1) << (FRAC_BITS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_RUN, ST_DONE} state_t;

  state_t state;

  // configuration
  logic [7:0]  surf_count;
  logic [30:0] surface_max;
  logic [30:0] ref_area;

  always_ff @(posedge clk) begin
    if (rst) begin
      surf_count  <= 8'd10;
      surface_max <= '0;
      ref_area    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SURF_COUNT:  surf_count  <= cfg_data[7:0];
        REG_SURFACE_MAX: surface_max <= cfg_data;
        REG_REF_AREA:    ref_area    <= cfg_data;
        default: ;
      endcase
    end
  end

  // coefficient memory with per-entry loaded flags
  logic [31:0]         coef_mem [COEF_COUNT];
  logic [COEF_COUNT-1:0] coef_ok;
  logic [COEF_AW-1:0]  rd_addr;
  logic [31:0]         rd_data;
  logic                rd_ok;
  logic                load_we;

  assign load_we = in_valid && !in_stall && cmd == CMD_LOAD &&
                   coef_index < 5'(COEF_COUNT);

  always_ff @(posedge clk) begin
    if (load_we) coef_mem[coef_index] <= coef_value;
    rd_data <= coef_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) coef_ok <= '0;
    else if (load_we) coef_ok[coef_index] <= 1'b1;
    rd_ok <= coef_ok[rd_addr];
  end

  // sequencer registers
  logic [5:0]  op;
  logic        phase;
  logic [5:0]  op_nxt;
  uop_t        u;
  uop_t        u_nxt;

  // operands of the transaction
  logic [31:0] mp1, mp2, mp3, mp4, mp5, mp6;
  logic [31:0] alt, vz, v, rho, target, half;
  // per-surface temporaries
  logic [31:0] s2, s3, s4, ext, e2, acc, t, d;
  logic [30:0] s;

  // spacing state
  logic [7:0]  dv;
  logic [30:0] dq;
  logic [8:0]  rem;
  logic [4:0]  bcnt;
  logic [7:0]  r0;
  logic [30:0] q0;
  logic [7:0]  racc;
  logic [7:0]  kcnt;
  logic [30:0] smax;

  // best so far
  logic [30:0] best;
  logic [32:0] best_err;

  assign u      = uop_of(op);
  assign op_nxt = (op == OP_LAST) ? OP_SURF_FIRST : op + 6'd1;
  assign u_nxt  = uop_of(op_nxt);

  // address of the operation that multiplies in the next cycle
  always_comb begin
    if (state == ST_RUN && phase) rd_addr = u_nxt.caddr;
    else rd_addr = u.caddr;
  end

  // operand selection
  function automatic logic [31:0] pick(input src_t sel, input logic [31:0] cval,
                                       input logic [31:0] m1, input logic [31:0] m2,
                                       input logic [31:0] m3, input logic [31:0] m4,
                                       input logic [31:0] m5, input logic [31:0] m6);
    logic [31:0] r;
    case (sel)
      SRC_COEF:  r = cval;
      SRC_ONE:   r = ONE;
      SRC_HALFC: r = HALFC;
      SRC_RHO:   r = rho;
      SRC_MP1:   r = m1;
      SRC_MP2:   r = m2;
      SRC_MP3:   r = m3;
      SRC_MP4:   r = m4;
      SRC_MP5:   r = m5;
      SRC_MP6:   r = m6;
      SRC_S:     r = {1'b0, s};
      SRC_S2:    r = s2;
      SRC_S3:    r = s3;
      SRC_S4:    r = s4;
      SRC_EXT:   r = ext;
      SRC_E2:    r = e2;
      SRC_ACC:   r = acc;
      SRC_T:     r = t;
      SRC_D:     r = d;
      SRC_HALF:  r = half;
      SRC_AREA:  r = {1'b0, ref_area};
      SRC_VZ:    r = vz;
      SRC_V:     r = v;
      SRC_ALT:   r = alt;
      default:   r = '0;
    endcase
    return r;
  endfunction

  logic [31:0] cval, a_val, b_val, res;
  logic        mul_en;

  assign cval   = rd_ok ? rd_data : 32'd0;
  assign a_val  = pick(u.a_sel, cval, mp1, mp2, mp3, mp4, mp5, mp6);
  assign b_val  = pick(u.b_sel, cval, mp1, mp2, mp3, mp4, mp5, mp6);
  assign mul_en = state == ST_RUN && !phase;

  dsgs_fmul #(.FRAC_BITS(FRAC_BITS)) u_fmul (
    .clk (clk),
    .en  (mul_en),
    .a   (a_val),
    .b   (b_val),
    .y   (res)
  );

  // divider trial and surface stepping
  logic [8:0]  trial;
  logic        tbit;
  logic [8:0]  rsum;
  logic        rwrap;
  logic [32:0] diff, err;
  logic        better;

  assign trial = {rem[7:0], dq[30]};
  assign tbit  = trial >= {1'b0, dv};
  assign rsum  = {1'b0, racc} + {1'b0, r0};
  assign rwrap = rsum >= {1'b0, dv};
  assign diff  = {target[31], target} - {res[31], res};
  assign err   = diff[32] ? 33'(-diff) : diff;
  assign better = kcnt == 8'd0 || err < best_err;

  assign in_stall = rst || state != ST_IDLE;

  // control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= 1'b0;
      op        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid && cmd == CMD_COMPUTE) begin
            mp1    <= mach;
            alt    <= altitude;
            vz     <= vert_speed;
            v      <= speed;
            rho    <= density;
            target <= target_drag;
            dv     <= (surf_count > 8'd1) ? surf_count - 8'd1 : 8'd1;
            dq     <= surface_max;
            smax   <= surface_max;
            rem    <= '0;
            bcnt   <= '0;
            op     <= '0;
            phase  <= 1'b0;
            best   <= '0;
            state  <= (surf_count == 8'd0) ? ST_DONE : ST_DIV;
          end
        end
        ST_DIV: begin
          // one quotient bit per cycle
          rem  <= tbit ? trial - {1'b0, dv} : trial;
          dq   <= {dq[29:0], tbit};
          bcnt <= bcnt + 5'd1;
          if (bcnt == 5'd30) begin
            q0    <= {dq[29:0], tbit};
            r0    <= tbit ? 8'(trial - {1'b0, dv}) : trial[7:0];
            s     <= '0;
            racc  <= '0;
            kcnt  <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          phase <= !phase;
          if (phase) begin
            op <= op_nxt;
            case (u.dst)
              DST_MP2:  mp2  <= res;
              DST_MP3:  mp3  <= res;
              DST_MP4:  mp4  <= res;
              DST_MP5:  mp5  <= res;
              DST_MP6:  mp6  <= res;
              DST_HALF: half <= res;
              DST_S2:   s2   <= res;
              DST_S3:   s3   <= res;
              DST_S4:   s4   <= res;
              DST_ACC:  acc  <= res;
              DST_ADD:  acc  <= sat_add(acc, res);
              DST_EXT:  ext  <= sat_add(acc, res);
              DST_E2:   e2   <= res;
              DST_T:    t    <= res;
              DST_D:    d    <= res;
              DST_DRAG: begin
                if (better) begin
                  best     <= s;
                  best_err <= err;
                end
                // step to the next surface
                racc <= rwrap ? 8'(rsum - {1'b0, dv}) : rsum[7:0];
                s    <= s + q0 + {30'd0, rwrap};
                kcnt <= kcnt + 8'd1;
                if ({1'b0, kcnt} + 9'd1 == {1'b0, surf_count}) state <= ST_DONE;
              end
              default: ;
            endcase
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            best_surface <= best;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // schedule stays inside the operation list
  a_op_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> op <= OP_LAST)
    else $error("operation index past end of schedule");

  // spacing remainders stay below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> (r0 < dv && racc < dv))
    else $error("spacing remainder out of range");

  // surfaces never pass the largest surface
  a_surf_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> s <= smax)
    else $error("surface beyond largest surface");

  // a result appears only out of the done state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result presented without a finished search");

endmodule

`default_nettype wire
